[rtl/apsp_pkg.sv]
// Package for the all-pairs shortest path block: matrix size, opcodes and
// the saturating distance add. Used by all_pairs_shortest_path.
// No dependencies.
package apsp_pkg;

  localparam int MaxVertices = 64;
  localparam int VertW       = $clog2(MaxVertices);
  localparam int AddrW       = 2 * VertW;
  localparam int MemDepth    = 1 << AddrW;
  localparam int CountW      = 7;
  localparam int DistW       = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef logic signed [DistW-1:0] dist_t;
  typedef logic [VertW-1:0]        vert_t;
  typedef logic [AddrW-1:0]        addr_t;

  // Signed add clamped to the 16-bit range.
  function automatic dist_t sat_add(dist_t a, dist_t b);
    logic signed [DistW:0] s;
    dist_t r;
    s = {a[DistW-1], a} + {b[DistW-1], b};
    if (s[DistW] != s[DistW-1]) begin
      r = s[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end else begin
      r = s[DistW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/all_pairs_shortest_path.sv]
// All-pairs shortest path block: distance matrix in a 2-read, 1-write RAM
// with a Floyd-Warshall sweep engine. Depends on apsp_pkg.
//
// Load, read and unused-opcode commands are taken one per cycle while busy_o is
// low; each gives one result word on the cycle after it is accepted, marked
// by result_valid_o, and the receiver cannot stall it. A solve with n =
// min(vertex_count, MaxVertices) vertices holds busy_o high through the sweep
// and gives its result word in the same cycle that busy_o falls (n below 2:
// like the other commands). Each (k, i) row first fetches d[i][k], then
// streams d[i][j] and d[k][j] through the two read ports, one update written
// back per cycle.
module all_pairs_shortest_path (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  op_i,
  input  logic [5:0]                  row_i,
  input  logic [5:0]                  col_i,
  input  logic signed [7:0]           weight_i,
  output logic                        result_valid_o,
  output logic signed [15:0]          distance_o,
  output logic [1:0]                  done_op_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [6:0]                  cfg_data_i
);
  import apsp_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ROW   = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  dist_t mem [MemDepth];

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] vcount_q;
  vert_t             k_q, k_d, i_q, i_d, j_q, j_d, last_q, last_d;
  vert_t             pi_q, pj_q;
  logic              pv_q, pv_d;
  logic              first_q, first_d;
  dist_t             dik_q;
  dist_t             rd_a_q, rd_b_q;
  logic              res_valid_q, res_valid_d;
  logic [1:0]        res_op_q, res_op_d;
  logic              res_rd_q, res_rd_d;

  addr_t ra, rb, wa;
  dist_t wd, via;
  logic  we, upd, accept, in_range;
  vert_t row_v, col_v;

  assign accept   = start_i && (state_q == S_IDLE);
  assign row_v    = VertW'(row_i);
  assign col_v    = VertW'(col_i);
  assign in_range = (int'(row_i) < MaxVertices) && (int'(col_i) < MaxVertices);

  // update stage: one candidate path per cycle during the sweep
  assign via = sat_add(dik_q, rd_b_q);
  assign upd = pv_q && (pi_q != pj_q) && (via < rd_a_q);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    last_d      = last_q;
    pv_d        = 1'b0;
    first_d     = 1'b0;
    res_valid_d = 1'b0;
    res_op_d    = res_op_q;
    res_rd_d    = 1'b0;
    ra          = {row_v, col_v};
    rb          = {k_q, j_q};
    wa          = {pi_q, pj_q};
    wd          = via;
    we          = upd;
    case (state_q)
      S_IDLE: begin
        wa = {row_v, col_v};
        wd = DistW'(weight_i);
        we = accept && (op_i == OP_LOAD) && in_range;
        if (accept) begin
          res_op_d    = op_i;
          res_valid_d = 1'b1;
          res_rd_d    = (op_i == OP_READ) && in_range;
          if (op_i == OP_SOLVE && vcount_q >= CountW'(2)) begin
            res_valid_d = 1'b0;
            k_d         = '0;
            i_d         = '0;
            j_d         = '0;
            last_d      = (int'(vcount_q) > MaxVertices) ? VertW'(MaxVertices - 1)
                                                         : VertW'(vcount_q - CountW'(1));
            state_d     = S_ROW;
          end
        end
      end
      S_ROW: begin
        ra      = {i_q, k_q};
        first_d = 1'b1;
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        ra   = {i_q, j_q};
        rb   = {k_q, j_q};
        pv_d = 1'b1;
        if (j_q == last_q) begin
          j_d = '0;
          if (i_q == last_q) begin
            i_d = '0;
            if (k_q == last_q) begin
              state_d = S_DRAIN;
            end else begin
              k_d     = k_q + 1'b1;
              state_d = S_ROW;
            end
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_ROW;
          end
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_DRAIN: begin
        res_valid_d = 1'b1;
        res_op_d    = OP_SOLVE;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  // hold d[i][k] for the row; forward it when the row rewrites that entry
  always_ff @(posedge clk_i) begin
    pi_q <= i_q;
    pj_q <= j_q;
    if (first_q) begin
      dik_q <= rd_a_q;
    end else if (upd && pj_q == k_q) begin
      dik_q <= via;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= CountW'(2);
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      last_q      <= '0;
      pv_q        <= 1'b0;
      first_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_op_q    <= OP_LOAD;
      res_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      last_q      <= last_d;
      pv_q        <= pv_d;
      first_q     <= first_d;
      res_valid_q <= res_valid_d;
      res_op_q    <= res_op_d;
      res_rd_q    <= res_rd_d;
      if (cfg_valid_i && cfg_ready_o) begin
        vcount_q <= cfg_data_i;
      end
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = res_valid_q;
  assign done_op_o      = res_op_q;
  assign distance_o     = res_rd_q ? rd_a_q : '0;

endmodule

[bench/tb.sv]
// Testbench for all_pairs_shortest_path: loads, solves, reads and unused
// opcodes against an in-order predictor of the distance matrix, with
// vertex_count stepped through small and zero/one values.
// Depends on apsp_pkg and the all_pairs_shortest_path RTL.
module tb;
  import apsp_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RandomItems = 550;
  localparam int         CycleLimit  = 4_000_000;

  typedef struct packed {
    dist_t      distance;
    logic [1:0] done_op;
  } apsp_result_t;

  class apsp_scoreboard;
    dist_t             dist_mem [MemDepth];
    logic [CountW-1:0] vertex_count;
    apsp_result_t      expected_q[$];
    int fails, checked, n_load, n_solve, n_read, n_unused;

    function new();
      vertex_count = 7'd2;
      foreach (dist_mem[a]) dist_mem[a] = '0;
    endfunction

    function void set_vertex_count(logic [CountW-1:0] value);
      vertex_count = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_failure(string msg);
      fails++;
      if (fails <= 10) $display("%s", msg);
    endfunction

    // Predict the result word of one accepted command.
    function void note_item(logic [1:0] op, vert_t row, vert_t col,
                            logic signed [7:0] weight);
      apsp_result_t want;
      int n;
      int via;
      want.distance = '0;
      want.done_op  = op;
      case (op)
        OP_LOAD: begin
          dist_mem[{row, col}] = {{(DistW-8){weight[7]}}, weight};
          n_load++;
        end
        OP_SOLVE: begin
          n = (vertex_count > MaxVertices) ? MaxVertices : int'(vertex_count);
          for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
              for (int j = 0; j < n; j++) begin
                if (i != j) begin
                  via = int'(dist_mem[i*MaxVertices + k]) +
                        int'(dist_mem[k*MaxVertices + j]);
                  if (via > 32767) via = 32767;
                  else if (via < -32768) via = -32768;
                  if (via < int'(dist_mem[i*MaxVertices + j]))
                    dist_mem[i*MaxVertices + j] = via[DistW-1:0];
                end
              end
          n_solve++;
        end
        OP_READ: begin
          want.distance = dist_mem[{row, col}];
          n_read++;
        end
        default: n_unused++;
      endcase
      expected_q.push_back(want);
    endfunction

    function void check_result(dist_t distance, logic [1:0] done_op);
      apsp_result_t want;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result word: distance %0d done_op %0d",
                               distance, done_op));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (done_op !== want.done_op)
        note_failure($sformatf("word %0d: done_op expected %0d, got %0d",
                               checked, want.done_op, done_op));
      if (distance !== want.distance)
        note_failure($sformatf("word %0d (op %0d): distance expected %0d, got %0d",
                               checked, want.done_op, want.distance, distance));
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic [1:0]        op_i        = '0;
  vert_t             row_i       = '0;
  vert_t             col_i       = '0;
  logic signed [7:0] weight_i    = '0;
  logic              cfg_valid_i = 1'b0;
  logic [CountW-1:0] cfg_data_i  = '0;
  logic              busy_o;
  logic              result_valid_o;
  dist_t             distance_o;
  logic [1:0]        done_op_o;
  logic              cfg_ready_o;

  apsp_scoreboard sb = new();

  bit loaded [MemDepth];
  int full_n;     // top-left square known to be loaded
  bit no_gaps;
  int issued;
  int cfg_writes;
  int cycles;

  all_pairs_shortest_path u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .weight_i       (weight_i),
    .result_valid_o (result_valid_o),
    .distance_o     (distance_o),
    .done_op_o      (done_op_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(distance_o, done_op_o);
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [7:0] pick_weight(int style);
    int w;
    case (style)
      0: w = int'($urandom_range(0, 255)) - 128;
      1: w = -int'($urandom_range(1, 128));
      2: w = ($urandom_range(0, 7) == 0) ? -int'($urandom_range(1, 20))
                                         : int'($urandom_range(0, 127));
      default: begin
        case ($urandom_range(0, 3))
          0: w = -128;
          1: w = -1;
          2: w = 0;
          default: w = 127;
        endcase
      end
    endcase
    return w[7:0];
  endfunction

  // Hold start high (no drop between back-to-back words) until accepted.
  task automatic send_cmd(int gap, logic [1:0] op, vert_t row, vert_t col,
                          logic signed [7:0] weight);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i  <= 1'b1;
    op_i     <= op;
    row_i    <= row;
    col_i    <= col;
    weight_i <= weight;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(op, row, col, weight);
    if (op == OP_LOAD) loaded[{row, col}] = 1'b1;
    issued++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0 || busy_o);
  endtask

  task automatic write_vertex_count(logic [CountW-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_vertex_count(value);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic load_square(int n, int style);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        send_cmd(pick_gap(), OP_LOAD, vert_t'(r), vert_t'(c), pick_weight(style));
    if (n > full_n) full_n = n;
  endtask

  // One phase: new vertex_count, usually a fresh matrix, then mixed commands.
  task automatic run_phase();
    int    n;
    int    r;
    int    style;
    int    extra;
    bit    broken;
    bit    solve_ok;
    vert_t row;
    vert_t col;
    r = $urandom_range(0, 99);
    if (r < 8) n = $urandom_range(0, 1);
    else if (r < 20) n = $urandom_range(9, 12);
    else n = $urandom_range(2, 8);
    write_vertex_count(n[CountW-1:0]);
    no_gaps  = ($urandom_range(0, 3) == 0);
    broken   = ($urandom_range(0, 5) == 0);
    style    = $urandom_range(0, 3);
    if (!broken && n >= 2) load_square(n, style);
    solve_ok = (n < 2) || (n <= full_n);
    extra    = $urandom_range(4, 20);
    repeat (extra) begin
      r   = $urandom_range(0, 99);
      row = vert_t'($urandom_range(0, 63));
      col = vert_t'($urandom_range(0, 63));
      if (r < 35) begin
        send_cmd(pick_gap(), OP_LOAD, row, col, pick_weight(style));
      end else if (r < 70) begin
        // read only entries that hold a loaded value
        if ($urandom_range(0, 1) || !loaded[{row, col}]) begin
          row = vert_t'($urandom_range(0, full_n - 1));
          col = vert_t'($urandom_range(0, full_n - 1));
        end
        send_cmd(pick_gap(), OP_READ, row, col, pick_weight(0));
      end else if (r < 85 && solve_ok) begin
        send_cmd(pick_gap(), OP_SOLVE, row, col, pick_weight(0));
      end else if (r < 95) begin
        send_cmd(pick_gap(), OP_UNUSED, row, col, pick_weight(0));
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    int base;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset vertex_count of two, extreme indexes and weights,
    // a negative cycle, unused opcode, then counts of zero and one.
    send_cmd(pick_gap(), OP_LOAD, 6'd0, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_LOAD, 6'd0, 6'd1, 8'h7F);
    send_cmd(pick_gap(), OP_LOAD, 6'd1, 6'd0, 8'h80);
    send_cmd(pick_gap(), OP_LOAD, 6'd1, 6'd1, 8'hFF);
    full_n = 2;
    send_cmd(pick_gap(), OP_READ, 6'd0, 6'd1, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd1, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_LOAD, 6'd63, 6'd63, 8'h80);
    send_cmd(pick_gap(), OP_LOAD, 6'd63, 6'd0, 8'h7F);
    send_cmd(pick_gap(), OP_LOAD, 6'd0, 6'd63, 8'hFF);
    send_cmd(pick_gap(), OP_READ, 6'd63, 6'd63, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd63, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd0, 6'd63, 8'h00);
    send_cmd(pick_gap(), OP_UNUSED, 6'd63, 6'd63, 8'hFF);
    send_cmd(pick_gap(), OP_UNUSED, 6'd0, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_SOLVE, 6'd0, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd0, 6'd1, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd1, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_SOLVE, 6'd63, 6'd63, 8'hFF);
    send_cmd(pick_gap(), OP_READ, 6'd1, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd63, 6'd63, 8'h00);
    write_vertex_count(7'd0);
    send_cmd(pick_gap(), OP_SOLVE, 6'd1, 6'd1, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd1, 6'd0, 8'h00);
    write_vertex_count(7'd1);
    send_cmd(pick_gap(), OP_SOLVE, 6'd0, 6'd0, 8'h00);
    send_cmd(pick_gap(), OP_READ, 6'd0, 6'd1, 8'h00);

    base = issued;
    while (issued - base < RandomItems) begin
      run_phase();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d commands: %0d loads, %0d solves, %0d reads, %0d unused-op",
             issued, sb.n_load, sb.n_solve, sb.n_read, sb.n_unused);
    $display("%0d vertex_count writes (0, 1 and up to 12); %0d result words checked",
             cfg_writes, sb.checked);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
